// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the curl noise RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CNVF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define CNVF_ASSERT_NEXT(lbl, ante, cons, msg) \
  `CNVF_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== hw/rtl/cnvf_pkg.sv =====
// Shared types, constants and helper functions of the curl noise block.
package cnvf_pkg;

  localparam int MAX_OCTAVES = 4;
  localparam int FRAC_BITS   = 16;

  localparam int IN_W    = 32;
  localparam int FREQ_W  = 24;
  localparam int OCTR_W  = 3;
  localparam int OCT_W   = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int PROD_W  = IN_W + FREQ_W + 1;
  localparam int Q_W     = PROD_W - (32 - FRAC_BITS);
  localparam int CRD_W   = FRAC_BITS + 32 + MAX_OCTAVES;
  localparam int T_W     = FRAC_BITS;
  localparam int W_W     = FRAC_BITS + 2;
  localparam int V_W     = 18;
  localparam int D_W     = V_W + MAX_OCTAVES + 3;
  localparam int EPS     = ((1 << FRAC_BITS) + 5) / 10;

  localparam logic [31:0] HASH_X   = 32'h8DA6B343;
  localparam logic [31:0] HASH_Y   = 32'hD8163841;
  localparam logic [31:0] HASH_Z   = 32'hCB1AB31F;
  localparam logic [31:0] PCG_MUL  = 32'd747796405;
  localparam logic [31:0] PCG_INC  = 32'd2891336453;
  localparam logic [31:0] PCG_MUL2 = 32'd277803737;

  localparam logic [2:0] LSTEP_LAST = 3'd6;

  typedef struct packed {
    logic signed [IN_W-1:0] pos_x;
    logic signed [IN_W-1:0] pos_y;
    logic signed [IN_W-1:0] pos_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] curl_x;
    logic signed [31:0] curl_y;
    logic signed [31:0] curl_z;
  } out_word_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCALE,
    OP_COORD,
    OP_SQ,
    OP_WT,
    OP_HMUL,
    OP_H0,
    OP_H1,
    OP_H2,
    OP_LERP,
    OP_ACC
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [1:0]       ax;
    logic [2:0]       pot;
    logic [OCT_W-1:0] oct;
    logic [1:0]       seed;
    logic [2:0]       corner;
    logic [2:0]       lstep;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  function automatic logic [31:0] axis_hash(input logic [1:0] ax);
    logic [31:0] c;
    unique case (ax)
      2'd0:    c = HASH_X;
      2'd1:    c = HASH_Y;
      default: c = HASH_Z;
    endcase
    return c;
  endfunction

  // seed * 0x165667B1 for the three fields
  function automatic logic [31:0] seed_hash(input logic [1:0] s);
    logic [31:0] c;
    unique case (s)
      2'd0:    c = 32'h00000000;
      2'd1:    c = 32'h165667B1;
      2'd2:    c = 32'h2CACCF62;
      default: c = 32'h43033713;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/cnvf_dp.sv =====
// Datapath: scaling, smoothstep, corner hashing, trilinear blend and curl sums.
module cnvf_dp
  import cnvf_pkg::*;
(
  input  logic              clk,
  input  cmd_t              cmd,
  input  in_word_t          in_data,
  input  logic [FREQ_W-1:0] freq,
  output out_word_t         curl
);

  localparam logic signed [CRD_W-1:0] EPS_C = CRD_W'(EPS);
  localparam logic [W_W-1:0] THREE = W_W'(3) << FRAC_BITS;
  localparam int L_W = V_W + W_W + 2;

  logic signed [IN_W-1:0]  pos   [3];
  logic signed [Q_W-1:0]   q     [3];
  logic [31:0]             lidx  [3];
  logic [T_W-1:0]          tf    [3];
  logic [W_W-1:0]          w     [3];
  logic [31:0]             hm    [3];
  logic [T_W-1:0]          t2;
  logic [31:0]             h;
  logic [31:0]             v1;
  logic signed [V_W-1:0]   cq    [8];
  logic signed [V_W-1:0]   rq    [4];
  logic signed [V_W-1:0]   nz;
  logic signed [D_W-1:0]   d     [9];

  logic signed [PROD_W-1:0] prod;
  logic signed [CRD_W-1:0]  coord [3];
  logic [2*T_W-1:0]         sq;
  logic [W_W-1:0]           fct;
  logic [T_W+W_W-1:0]       wprod;
  logic [31:0]              hprod;
  logic [31:0]              hsum;
  logic [4:0]               sh;
  logic [31:0]              mix;
  logic [31:0]              mprod;
  logic [31:0]              hfin;
  logic signed [V_W-1:0]    la;
  logic signed [V_W-1:0]    lb;
  logic [W_W-1:0]           lw;
  logic signed [V_W:0]      ldiff;
  logic signed [L_W-1:0]    lprod;
  logic signed [V_W-1:0]    lres;
  logic [3:0]               dsel;
  logic signed [D_W-1:0]    term;
  logic [OCT_W:0]           ash;

  function automatic logic [31:0] curl_scale(input logic signed [D_W:0] c);
    logic signed [63:0] x;
    x = 64'(c);
    x = (x <<< 2) + x;
    x = x >>> (MAX_OCTAVES - 1);
    return x[31:0];
  endfunction

  assign prod = PROD_W'(pos[cmd.ax]) * PROD_W'($signed({1'b0, freq}));

  // Offset the differentiated axis by plus or minus EPS (about 0.1), then scale by octave
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [CRD_W-1:0] s;
      s = CRD_W'(q[a]);
      if (cmd.pot[2:1] == 2'(a)) begin
        s = cmd.pot[0] ? s - EPS_C : s + EPS_C;
      end
      coord[a] = s <<< cmd.oct;
    end
  end

  assign sq    = tf[cmd.ax] * tf[cmd.ax];
  assign fct   = THREE - {1'b0, tf[cmd.ax], 1'b0};
  assign wprod = (T_W+W_W)'(t2) * (T_W+W_W)'(fct);
  assign hprod = lidx[cmd.ax] * axis_hash(cmd.ax);

  assign hsum = (hm[0] + (cmd.corner[0] ? HASH_X : 32'd0))
              ^ (hm[1] + (cmd.corner[1] ? HASH_Y : 32'd0))
              ^ (hm[2] + (cmd.corner[2] ? HASH_Z : 32'd0))
              ^ seed_hash(cmd.seed);

  assign sh    = {1'b0, v1[31:28]} + 5'd4;
  assign mix   = (v1 >> sh) ^ v1;
  assign mprod = mix * PCG_MUL2;
  assign hfin  = (mprod >> 22) ^ mprod;

  // Blend operands: x stage from corners, y and z stages from partial results
  always_comb begin
    if (!cmd.lstep[2]) begin
      la = cq[0];
      lb = cq[1];
      lw = w[0];
    end else if (cmd.lstep != LSTEP_LAST) begin
      la = rq[0];
      lb = rq[1];
      lw = w[1];
    end else begin
      la = rq[0];
      lb = rq[2];
      lw = w[2];
    end
  end

  assign ldiff = (V_W+1)'(lb) - (V_W+1)'(la);
  assign lprod = L_W'(ldiff) * L_W'($signed({1'b0, lw}));
  assign lres  = V_W'(L_W'(la) + (lprod >>> FRAC_BITS));

  assign dsel = 4'(cmd.pot[2:1]) * 4'd3 + 4'(cmd.seed);
  assign ash  = (OCT_W+1)'(MAX_OCTAVES - 1) - (OCT_W+1)'(cmd.oct);
  assign term = D_W'(nz) <<< ash;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        pos[0] <= in_data.pos_x;
        pos[1] <= in_data.pos_y;
        pos[2] <= in_data.pos_z;
        for (int i = 0; i < 9; i++) begin
          d[i] <= '0;
        end
      end
      OP_SCALE: q[cmd.ax] <= prod[PROD_W-1:32-FRAC_BITS];
      OP_COORD: begin
        for (int a = 0; a < 3; a++) begin
          lidx[a] <= coord[a][FRAC_BITS+31:FRAC_BITS];
          tf[a]   <= coord[a][FRAC_BITS-1:0];
        end
      end
      OP_SQ:   t2 <= sq[2*T_W-1:T_W];
      OP_WT:   w[cmd.ax] <= wprod[T_W+W_W-1:T_W];
      OP_HMUL: hm[cmd.ax] <= hprod;
      OP_H0:   h <= hsum;
      OP_H1:   v1 <= h * PCG_MUL + PCG_INC;
      OP_H2: begin
        for (int i = 0; i < 7; i++) begin
          cq[i] <= cq[i+1];
        end
        cq[7] <= $signed({{(V_W-16){1'b0}}, hfin[31:16]});
      end
      OP_LERP: begin
        for (int i = 0; i < 6; i++) begin
          cq[i] <= cq[i+2];
        end
        if (!cmd.lstep[2]) begin
          for (int i = 0; i < 3; i++) begin
            rq[i] <= rq[i+1];
          end
        end else begin
          rq[0] <= rq[2];
          rq[1] <= rq[3];
          rq[2] <= lres;
        end
        rq[3] <= lres;
        nz    <= lres;
      end
      OP_ACC: d[dsel] <= cmd.pot[0] ? d[dsel] - term : d[dsel] + term;
      default: ;
    endcase
  end

  assign curl.curl_x = curl_scale((D_W+1)'(d[5]) - (D_W+1)'(d[7]));
  assign curl.curl_y = curl_scale((D_W+1)'(d[6]) - (D_W+1)'(d[2]));
  assign curl.curl_z = curl_scale((D_W+1)'(d[1]) - (D_W+1)'(d[3]));

endmodule

// ===== hw/rtl/cnvf_ctrl.sv =====
// Controller: sequences potentials, octaves, fields, corners and blend steps.
`include "assert_macros.svh"
module cnvf_ctrl
  import cnvf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  sts_t              sts,
  input  logic [OCTR_W-1:0] octr,
  output logic              busy,
  output logic              load_out,
  output cmd_t              cmd
);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b000000000001,
    ST_SCALE = 12'b000000000010,
    ST_COORD = 12'b000000000100,
    ST_SQ    = 12'b000000001000,
    ST_WT    = 12'b000000010000,
    ST_HMUL  = 12'b000000100000,
    ST_H0    = 12'b000001000000,
    ST_H1    = 12'b000010000000,
    ST_H2    = 12'b000100000000,
    ST_LERP  = 12'b001000000000,
    ST_ACC   = 12'b010000000000,
    ST_DONE  = 12'b100000000000
  } state_t;

  state_t           state, state_next;
  logic [1:0]       ax, ax_next;
  logic [2:0]       pot, pot_next;
  logic [OCT_W-1:0] oct, oct_next;
  logic [1:0]       seed, seed_next;
  logic [2:0]       corner, corner_next;
  logic [2:0]       lstep, lstep_next;
  logic [OCT_W-1:0] oct_last;

  // Clamp the octave register into 1..MAX_OCTAVES
  always_comb begin
    if (octr == '0) begin
      oct_last = '0;
    end else if (32'(octr) > MAX_OCTAVES) begin
      oct_last = OCT_W'(MAX_OCTAVES - 1);
    end else begin
      oct_last = OCT_W'(octr - 1'b1);
    end
  end

  always_comb begin
    state_next  = state;
    ax_next     = ax;
    pot_next    = pot;
    oct_next    = oct;
    seed_next   = seed;
    corner_next = corner;
    lstep_next  = lstep;
    load_out    = 1'b0;
    cmd.op      = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        ax_next     = '0;
        pot_next    = '0;
        oct_next    = '0;
        seed_next   = '0;
        corner_next = '0;
        lstep_next  = '0;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.op  = OP_SCALE;
        ax_next = ax + 2'd1;
        if (ax == 2'd2) begin
          ax_next    = '0;
          state_next = ST_COORD;
        end
      end
      ST_COORD: begin
        cmd.op     = OP_COORD;
        ax_next    = '0;
        state_next = ST_SQ;
      end
      ST_SQ: begin
        cmd.op     = OP_SQ;
        state_next = ST_WT;
      end
      ST_WT: begin
        cmd.op  = OP_WT;
        ax_next = ax + 2'd1;
        state_next = ST_SQ;
        if (ax == 2'd2) begin
          ax_next    = '0;
          state_next = ST_HMUL;
        end
      end
      ST_HMUL: begin
        cmd.op  = OP_HMUL;
        ax_next = ax + 2'd1;
        if (ax == 2'd2) begin
          ax_next     = '0;
          seed_next   = '0;
          corner_next = '0;
          state_next  = ST_H0;
        end
      end
      ST_H0: begin
        cmd.op     = OP_H0;
        state_next = ST_H1;
      end
      ST_H1: begin
        cmd.op     = OP_H1;
        state_next = ST_H2;
      end
      ST_H2: begin
        cmd.op      = OP_H2;
        corner_next = corner + 3'd1;
        state_next  = ST_H0;
        if (corner == 3'd7) begin
          lstep_next = '0;
          state_next = ST_LERP;
        end
      end
      ST_LERP: begin
        cmd.op     = OP_LERP;
        lstep_next = lstep + 3'd1;
        if (lstep == LSTEP_LAST) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.op      = OP_ACC;
        corner_next = '0;
        if (seed != 2'd2) begin
          seed_next  = seed + 2'd1;
          state_next = ST_H0;
        end else begin
          seed_next = '0;
          if (oct != oct_last) begin
            oct_next   = oct + 1'b1;
            state_next = ST_COORD;
          end else begin
            oct_next = '0;
            if (pot == 3'd5) begin
              state_next = ST_DONE;
            end else begin
              pot_next   = pot + 3'd1;
              state_next = ST_COORD;
            end
          end
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign cmd.ax     = ax;
  assign cmd.pot    = pot;
  assign cmd.oct    = oct;
  assign cmd.seed   = seed;
  assign cmd.corner = corner;
  assign cmd.lstep  = lstep;
  assign busy       = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      ax     <= '0;
      pot    <= '0;
      oct    <= '0;
      seed   <= '0;
      corner <= '0;
      lstep  <= '0;
    end else begin
      state  <= state_next;
      ax     <= ax_next;
      pot    <= pot_next;
      oct    <= oct_next;
      seed   <= seed_next;
      corner <= corner_next;
      lstep  <= lstep_next;
    end
  end

  `CNVF_ASSERT_NEXT(a_last_corner_blends, state == ST_H2 && corner == 3'd7, state == ST_LERP, "eighth corner not followed by blend")
  `CNVF_ASSERT_NEXT(a_done_holds, state == ST_DONE && !sts.out_free, state == ST_DONE, "result dropped while output full")
  `CNVF_ASSERT(a_seed_range, seed != 2'd3, "field index out of range")

endmodule

// ===== hw/rtl/curl_noise_value_fbm.sv =====
// Top level of the curl noise block: configuration registers, control, datapath, output.
//
// Usage:
//   Input channel (in_valid, in_stall, in_data) carries one position word
//   (pos_x, pos_y, pos_z, signed Q15.16). A word is taken when in_valid is high and
//   in_stall is low; in_stall stays high while a position is being worked on.
//   Output channel (out_valid, out_stall, out_data) carries the curl word
//   (curl_x, curl_y, curl_z, signed Q15.16), one per input word.
//   Words are handled one at a time: a new word is not accepted until the last
//   one is handed to the output register. N is the clamped octave count (1..4).
//   The three axes are scaled, then per potential and each of the N octaves: a
//   coordinate step, smoothstep weights for each axis, three lattice multiplies,
//   then for each of three fields eight corners hashed in steps H0, H1 and H2, a
//   trilinear blend over x, y and z and a sum step, all on one shared hash and
//   blend unit; a last step hands the word to the output register.
//   A finished word waits in the output register; the next position is accepted
//   while it waits. If the receiver still stalls when the next word is done, hold
//   it in the controller until the output register frees.
//   Reset (rst, synchronous) empties the output, returns control to idle and sets
//   noise_frequency to 1.0 and octave_count to 1. Write the APB registers only while idle.
`include "assert_macros.svh"
module curl_noise_value_fbm
  import cnvf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [FREQ_W-1:0] freq;
  logic [OCTR_W-1:0] octr;
  logic              busy;
  logic              load_out;
  cmd_t              cmd;
  sts_t              sts;
  out_word_t         curl;
  logic              cfg_wr;

  // APB: register 0 at byte 0 (frequency), register 1 at byte 4 (octaves)
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = paddr[2] ? {{(32-OCTR_W){1'b0}}, octr} : {{(32-FREQ_W){1'b0}}, freq};

  always_ff @(posedge clk) begin
    if (rst) begin
      freq <= FREQ_W'(1 << FRAC_BITS);
      octr <= OCTR_W'(1);
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        octr <= pwdata[OCTR_W-1:0];
      end else begin
        freq <= pwdata[FREQ_W-1:0];
      end
    end
  end

  // Output slot frees when empty or being taken this cycle
  assign sts.out_free = ~out_valid | ~out_stall;
  assign in_stall     = busy;

  cnvf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .octr     (octr),
    .busy     (busy),
    .load_out (load_out),
    .cmd      (cmd)
  );

  cnvf_dp u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .in_data (in_data),
    .freq    (freq),
    .curl    (curl)
  );

  // Hold the word while stalled, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= curl;
    end
  end

  `CNVF_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "block idle after accepting a word")
  `CNVF_ASSERT_NEXT(a_load_shows, load_out, out_valid, "loaded result not presented")
  `CNVF_ASSERT(a_load_when_free, load_out |-> (!out_valid || !out_stall), "result loaded over a waiting word")

endmodule

// ===== verif/cnvf_tb_pkg.sv =====
`timescale 1ns / 100ps
// Register addresses shared by the curl noise testbench files.
package cnvf_tb_pkg;

  localparam logic [2:0] ADDR_FREQ = 3'd0;
  localparam logic [2:0] ADDR_OCT  = 3'd4;

endpackage

// ===== verif/cnvf_curl_checker.sv =====
`timescale 1ns / 100ps
// Checker of the curl noise block: tracks the registers, predicts each curl word, compares.
module cnvf_curl_checker
  import cnvf_pkg::*;
  import cnvf_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_word_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_word_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          curl_pending,
  output int          curl_seen
);

  logic [FREQ_W-1:0] freq_q;
  logic [OCTR_W-1:0] oct_q;
  out_word_t         curl_fifo[$];

  function automatic logic [31:0] pcg_mix(input logic [31:0] v);
    logic [31:0] s;
    s = v * PCG_MUL + PCG_INC;
    s = ((s >> ((s >> 28) + 32'd4)) ^ s) * PCG_MUL2;
    return (s >> 22) ^ s;
  endfunction

  function automatic longint lattice_val(input logic [31:0] x, y, z, input int seed);
    logic [31:0] h;
    h = x * HASH_X ^ y * HASH_Y ^ z * HASH_Z ^ (32'(seed) * 32'h165667B1);
    return longint'(pcg_mix(h) >> 16);
  endfunction

  function automatic longint smoothstep(input longint t);
    longint t2;
    t2 = (t * t) >>> FRAC_BITS;
    return (t2 * ((longint'(3) << FRAC_BITS) - 2 * t)) >>> FRAC_BITS;
  endfunction

  function automatic longint blend(input longint a, b, w);
    return a + (((b - a) * w) >>> FRAC_BITS);
  endfunction

  function automatic longint value_noise(input longint px, py, pz, input int seed);
    logic [31:0] ix, iy, iz;
    longint wx, wy, wz, x00, x10, x01, x11, y0, y1;
    longint fmask;
    fmask = (longint'(1) << FRAC_BITS) - 1;
    ix = 32'(px >>> FRAC_BITS);
    iy = 32'(py >>> FRAC_BITS);
    iz = 32'(pz >>> FRAC_BITS);
    wx = smoothstep(px & fmask);
    wy = smoothstep(py & fmask);
    wz = smoothstep(pz & fmask);
    x00 = blend(lattice_val(ix, iy, iz, seed), lattice_val(ix + 1, iy, iz, seed), wx);
    x10 = blend(lattice_val(ix, iy + 1, iz, seed), lattice_val(ix + 1, iy + 1, iz, seed), wx);
    x01 = blend(lattice_val(ix, iy, iz + 1, seed), lattice_val(ix + 1, iy, iz + 1, seed), wx);
    x11 = blend(lattice_val(ix, iy + 1, iz + 1, seed),
                lattice_val(ix + 1, iy + 1, iz + 1, seed), wx);
    y0 = blend(x00, x10, wy);
    y1 = blend(x01, x11, wy);
    return blend(y0, y1, wz);
  endfunction

  function automatic out_word_t predict_curl(input in_word_t w,
                                             input logic [FREQ_W-1:0] freq,
                                             input logic [OCTR_W-1:0] oct_raw);
    longint q[3], e[3], pot[6][3], d[3][3], c[3];
    int noct;
    out_word_t r;
    noct = (oct_raw < 1) ? 1 : (oct_raw > MAX_OCTAVES) ? MAX_OCTAVES : int'(oct_raw);
    q[0] = (longint'(w.pos_x) * longint'({40'd0, freq})) >>> (32 - FRAC_BITS);
    q[1] = (longint'(w.pos_y) * longint'({40'd0, freq})) >>> (32 - FRAC_BITS);
    q[2] = (longint'(w.pos_z) * longint'({40'd0, freq})) >>> (32 - FRAC_BITS);
    for (int a = 0; a < 3; a++) begin
      for (int sgn = 0; sgn < 2; sgn++) begin
        for (int k = 0; k < 3; k++) begin
          e[k] = (k == a) ? ((sgn == 0) ? EPS : -EPS) : 0;
          pot[2*a+sgn][k] = 0;
        end
        // accumulate octaves: frequency doubles, weight halves
        for (int o = 0; o < noct; o++) begin
          for (int s = 0; s < 3; s++) begin
            pot[2*a+sgn][s] += value_noise((q[0] + e[0]) << o, (q[1] + e[1]) << o,
                                           (q[2] + e[2]) << o, s)
                               << (MAX_OCTAVES - 1 - o);
          end
        end
      end
      for (int k = 0; k < 3; k++) d[a][k] = pot[2*a][k] - pot[2*a+1][k];
    end
    c[0] = d[1][2] - d[2][1];
    c[1] = d[2][0] - d[0][2];
    c[2] = d[0][1] - d[1][0];
    r.curl_x = 32'((c[0] * 5) >>> (MAX_OCTAVES - 1));
    r.curl_y = 32'((c[1] * 5) >>> (MAX_OCTAVES - 1));
    r.curl_z = 32'((c[2] * 5) >>> (MAX_OCTAVES - 1));
    return r;
  endfunction

  assign curl_pending = curl_fifo.size();

  always @(posedge clk) begin
    out_word_t exp_w;
    int errs;
    errs = 0;
    if (rst) begin
      freq_q <= 24'd65536;
      oct_q  <= 3'd1;
      fail_count <= 0;
      curl_seen  <= 0;
      curl_fifo.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_FREQ: freq_q <= pwdata[FREQ_W-1:0];
          ADDR_OCT:  oct_q  <= pwdata[OCTR_W-1:0];
          default: ;
        endcase
      end
      // check the output first: a word accepted now cannot answer this edge's input
      if (out_valid && !out_stall) begin
        curl_seen <= curl_seen + 1;
        if (curl_fifo.size() == 0) begin
          $error("curl word with nothing expected: %h", out_data);
          errs++;
        end else begin
          exp_w = curl_fifo.pop_front();
          if (out_data.curl_x !== exp_w.curl_x) begin
            $error("curl_x expected %0d got %0d", exp_w.curl_x, out_data.curl_x);
            errs++;
          end
          if (out_data.curl_y !== exp_w.curl_y) begin
            $error("curl_y expected %0d got %0d", exp_w.curl_y, out_data.curl_y);
            errs++;
          end
          if (out_data.curl_z !== exp_w.curl_z) begin
            $error("curl_z expected %0d got %0d", exp_w.curl_z, out_data.curl_z);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
      if (in_valid && !in_stall) begin
        curl_fifo.insert(curl_fifo.size(), predict_curl(in_data, freq_q, oct_q));
      end
    end
  end

endmodule

// ===== verif/tb_curl_noise_value_fbm.sv =====
`timescale 1ns / 100ps
// Testbench top of the curl noise block: stimulus, receiver, watchdog and verdict.
module tb_curl_noise_value_fbm;
  import cnvf_pkg::*;
  import cnvf_tb_pkg::*;

  localparam int HOLD_CYCLES = 4000;   // long receiver hold-off, fills the block
  localparam int STALL_LIMIT = 20000;  // cycles without any accepted word

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int curl_pending;
  int curl_seen;
  int pos_sent;
  int idle_run;
  bit idle_on;
  bit hold_req;

  curl_noise_value_fbm u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  cnvf_curl_checker u_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .curl_pending(curl_pending), .curl_seen(curl_seen)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Mostly no gap, often a short one, now and then a long one; never a gap while idle_on is clear.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Mix full-range, small, near-lattice and medium coordinates.
  function automatic logic signed [31:0] rand_coord();
    int unsigned kind;
    kind = $urandom_range(0, 3);
    case (kind)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      2: return ($signed($urandom_range(0, 64)) - 32) * 32'sh0001_0000
                + $signed($urandom_range(0, 16)) - 8;
      default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endcase
  endfunction

  task automatic send_pos(input logic signed [31:0] x, y, z);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{pos_x: x, pos_y: y, pos_z: z};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pos_sent++;
  endtask

  // Drop the input and wait until every expected word has come out.
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (curl_pending != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drain the block, then write both registers (upper data bits carry noise) and pick whether gaps are on.
  task automatic set_config(input logic [23:0] freq, input logic [2:0] oct);
    drain_block();
    repeat (20) @(posedge clk);
    apb_write(ADDR_FREQ, {8'($urandom_range(0, 255)), freq});
    apb_write(ADDR_OCT, {29'($urandom_range(0, 32'h1FFF_FFFF)), oct});
    idle_on = $urandom_range(0, 3) != 0;
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_pos(rand_coord(), rand_coord(), rand_coord());
  endtask

  // Extremes, the lattice edges, and huge coordinates that wrap the lattice index.
  task automatic send_corners();
    send_pos(32'sh0, 32'sh0, 32'sh0);
    send_pos(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_pos(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_pos(-32'sh1, 32'sh1, -32'sh1);
    send_pos(32'sh0001_0000, 32'sh0000_FFFF, 32'sh0000_8000);
    send_pos(32'shFFFF_0000, 32'sh7FFF_0000, 32'sh8000_FFFF);
    send_pos(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0);
    send_pos(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_F0F0);
    send_pos(32'sh0000_1999, -32'sh0000_1999, 32'sh0000_0001);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (pick_gap() > 0) begin
        out_stall <= 1'b1;
        repeat (pick_gap() + 1) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run if no word moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
      if (idle_run == STALL_LIMIT) begin
        $display("watchdog: no word moved in %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    idle_on  = 1'b1;
    hold_req = 1'b0;
    pos_sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: unit frequency, one octave
    send_corners();
    send_random(20);

    // widest frequency, octave count above range clamps to four
    set_config(24'hFFFFFF, 3'd7);
    send_corners();
    send_random(30);

    // zero frequency maps everything to the origin; zero octaves runs as one
    set_config(24'd0, 3'd0);
    send_random(50);

    set_config(24'd65536, 3'd2);
    send_random(150);

    set_config(24'd1, 3'd3);
    send_random(50);

    // one octave with a long receiver hold-off while positions keep coming
    set_config(24'($urandom), 3'd1);
    hold_req = 1'b1;
    send_random(100);
    drain_block();   // sender pause until drained
    send_random(100);

    set_config(24'h008000, 3'd4);
    send_random(50);

    set_config(24'($urandom), 3'd5);
    send_random(40);

    set_config(24'($urandom_range(0, 24'h040000)), 3'd2);
    send_random(200);

    drain_block();
    repeat (3000) @(posedge clk);

    $display("Sent %0d positions over nine register settings (frequency 0 to max,",
             pos_sent);
    $display("octave counts 0..7), checked %0d curl words, %0d mismatches.",
             curl_seen, fail_count);
    if (fail_count == 0 && curl_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
